@@ rtl/generational_handle_table_assert.svh @@
// Assertion macros shared by the generational handle table RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// Same-cycle implication checked on the rising edge of clk outside reset.
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on the rising edge of clk outside reset.
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ght_pkg.sv @@
// Shared types and constants for the generational handle table.
package ght_pkg;

  localparam int REF_W    = 64;
  localparam int HANDLE_W = 64;
  localparam int GEN_W    = 32;
  localparam int LIVE_W   = 9;

  localparam int IN_OBJ_LSB    = 0;
  localparam int IN_HANDLE_LSB = 64;
  localparam int IN_TDATA_W    = 128;

  localparam int OUT_HANDLE_LSB = 0;
  localparam int OUT_OBJ_LSB    = 64;
  localparam int OUT_LIVE_LSB   = 128;
  localparam int OUT_TDATA_W    = 144;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NULL  = 2'd1;
  localparam logic [1:0] STAT_STALE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic capture;
    logic commit;
  } ght_cmd_t;

  typedef struct packed {
    logic out_valid;
  } ght_status_t;

endpackage

@@ rtl/ght_ctrl.sv @@
// Controller state machine that sequences request capture and commit.
module ght_ctrl
  import ght_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        m_tready,
  input  ght_status_t sts,
  output logic        s_tready,
  output ght_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result register must be free or emptying before a commit.
        if (!sts.out_valid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/ght_datapath.sv @@
// Datapath with slot memories, free stack, counters and the result register.
module ght_datapath
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = 256
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  ght_cmd_t               cmd,
  output ght_status_t            sts,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [1:0]             m_tuser
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [REF_W-1:0] ref_mem [SLOT_COUNT];
  logic [GEN_W-1:0] gen_mem [SLOT_COUNT];
  logic [IW-1:0]    stk_mem [SLOT_COUNT];

  logic [1:0]          req_op;
  logic [REF_W-1:0]    req_ref;
  logic [HANDLE_W-1:0] req_handle;
  logic [REF_W-1:0]    ref_rd;
  logic [GEN_W-1:0]    gen_rd;
  logic [IW-1:0]       stk_rd;

  logic [CW-1:0]    free_depth;
  logic [CW-1:0]    high_water;
  logic [CW-1:0]    live_total;
  logic [GEN_W-1:0] next_gen;

  logic [CW-1:0]    free_depth_next;
  logic [CW-1:0]    high_water_next;
  logic [CW-1:0]    live_total_next;
  logic [GEN_W-1:0] next_gen_next;

  logic [CW-1:0]    fd_dec;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    wr_idx;
  logic [REF_W-1:0] ref_wd;
  logic [GEN_W-1:0] gen_wd;
  logic             slot_we;
  logic             stk_we;
  logic             add_ok;
  logic             hit;
  logic [GEN_W-1:0] gen_new;
  logic [31:0]      hidx;
  logic [GEN_W-1:0] hgen;
  logic [31:0]      hw_ext;

  logic [1:0]          res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [REF_W-1:0]    res_obj;
  logic [CW+LIVE_W-1:0] live_ext;

  logic                out_valid;
  logic [1:0]          out_status;
  logic [HANDLE_W-1:0] out_handle;
  logic [REF_W-1:0]    out_obj;
  logic [LIVE_W-1:0]   out_live;

  assign rd_idx = s_tdata[IN_HANDLE_LSB +: IW];
  assign fd_dec = free_depth - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op     <= s_tuser;
      req_ref    <= s_tdata[IN_OBJ_LSB +: REF_W];
      req_handle <= s_tdata[IN_HANDLE_LSB +: HANDLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      ref_mem[wr_idx] <= ref_wd;
    end
    if (cmd.capture) begin
      ref_rd <= ref_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      gen_mem[wr_idx] <= gen_wd;
    end
    if (cmd.capture) begin
      gen_rd <= gen_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[free_depth[IW-1:0]] <= wr_idx;
    end
    if (cmd.capture) begin
      stk_rd <= stk_mem[fd_dec[IW-1:0]];
    end
  end

  assign hidx    = req_handle[31:0];
  assign hgen    = req_handle[HANDLE_W-1:32];
  assign hw_ext  = {{(32-CW){1'b0}}, high_water};
  assign hit     = (hgen != '0) && (hidx < hw_ext) && (gen_rd == hgen);
  assign gen_new = (next_gen == '0) ? GEN_W'(1) : next_gen;

  always_comb begin
    res_status      = STAT_OK;
    res_handle      = '0;
    res_obj         = '0;
    free_depth_next = free_depth;
    high_water_next = high_water;
    live_total_next = live_total;
    next_gen_next   = next_gen;
    wr_idx          = req_handle[IW-1:0];
    ref_wd          = req_ref;
    gen_wd          = gen_new;
    slot_we         = 1'b0;
    stk_we          = 1'b0;
    add_ok          = 1'b0;
    case (req_op)
      OP_ADD: begin
        if (req_ref == '0) begin
          res_status = STAT_NULL;
        end else if (free_depth != '0 && free_depth <= CW'(SLOT_COUNT)) begin
          wr_idx          = stk_rd;
          free_depth_next = fd_dec;
          add_ok          = 1'b1;
        end else if (high_water < CW'(SLOT_COUNT)) begin
          wr_idx          = high_water[IW-1:0];
          high_water_next = high_water + CW'(1);
          add_ok          = 1'b1;
        end else begin
          res_status = STAT_FULL;
        end
        if (add_ok) begin
          slot_we         = 1'b1;
          live_total_next = live_total + CW'(1);
          next_gen_next   = (next_gen == '0) ? GEN_W'(2) : next_gen + GEN_W'(1);
          res_handle      = {gen_new, {(32-IW){1'b0}}, wr_idx};
        end
      end
      OP_RESOLVE: begin
        if (req_handle == '0) begin
          res_status = STAT_NULL;
        end else if (hit) begin
          res_obj = ref_rd;
        end else begin
          res_status = STAT_STALE;
        end
      end
      OP_REMOVE: begin
        if (req_handle == '0) begin
          res_status = STAT_NULL;
        end else if (hit) begin
          slot_we = 1'b1;
          ref_wd  = '0;
          gen_wd  = '0;
          if (free_depth < CW'(SLOT_COUNT)) begin
            stk_we          = 1'b1;
            free_depth_next = free_depth + CW'(1);
          end
          if (live_total != '0) begin
            live_total_next = live_total - CW'(1);
          end
        end else begin
          res_status = STAT_STALE;
        end
      end
      default: begin
        res_status = STAT_NULL;
      end
    endcase
    slot_we = slot_we & cmd.commit;
    stk_we  = stk_we & cmd.commit;
  end

  assign live_ext = {{LIVE_W{1'b0}}, live_total_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      high_water <= '0;
      live_total <= '0;
      next_gen   <= GEN_W'(1);
    end else if (cmd.commit) begin
      free_depth <= free_depth_next;
      high_water <= high_water_next;
      live_total <= live_total_next;
      next_gen   <= next_gen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_obj    <= res_obj;
      out_live   <= live_ext[LIVE_W-1:0];
    end
  end

  assign sts.out_valid = out_valid;
  assign m_tvalid      = out_valid;
  assign m_tuser       = out_status;
  assign m_tdata       = {{(OUT_TDATA_W-OUT_LIVE_LSB-LIVE_W){1'b0}}, out_live, out_obj,
                          out_handle};

endmodule

@@ rtl/generational_handle_table.sv @@
// A request transfer loads the request registers and the registered reads of the slot memories
// and free stack; a commit then writes back to the tables and loads the result register, which
// offers the result. A held result stalls the commit. No new request is accepted until the
// previous one commits.
// Reset clears the counters, the generation counter to one and the result valid flag.
// Slot memories and the free stack are not cleared; there is no clearing pass.
// Top level of the generational handle table.
`include "generational_handle_table_assert.svh"

module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT = 256
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // object_ref [63:0], handle [127:64]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // op [1:0]
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // handle_out [63:0], object_out [127:64], live_count [136:128], zero [143:137]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [1:0]             m_tuser
);

  ght_cmd_t    cmd;
  ght_status_t sts;

  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  ght_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `GHT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second transfer while busy")
  `GHT_ASSERT_NOW(a_fail_zero, m_tvalid && m_tuser != STAT_OK, m_tdata[127:0] == '0, "fail data")
  `GHT_ASSERT_NOW(a_gen_nonzero, m_tvalid && m_tdata[63:0] != '0, m_tdata[63:32] != '0, "zero gen")

endmodule

@@ verif/generational_handle_table_tb.sv @@
// Self-checking stream testbench for the generational handle table.
`timescale 1ns / 1ps

module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int SLOT_COUNT = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [63:0] handle_out;
    logic [63:0] object_out;
    logic [1:0] status;
    logic [8:0] live_count;
  } table_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  logic [63:0] slot_ref [SLOT_COUNT];
  logic [31:0] slot_gen [SLOT_COUNT];
  logic [7:0] free_idx [SLOT_COUNT];
  logic [8:0] free_top = '0;
  logic [8:0] water = '0;
  logic [8:0] live = '0;
  logic [31:0] gen_next = 32'd1;

  table_result_t pending_results[$];
  logic [63:0] live_handles[$];
  logic [63:0] dead_handles[$];

  int issued = 0;
  int retired = 0;
  int errors = 0;
  int cycle_count = 0;
  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int hold_cycles = 0;
  int add_weight = 40;

  generational_handle_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic table_result_t apply_to_table(logic [1:0] op, logic [63:0] obj,
                                                   logic [63:0] h);
    table_result_t res;
    logic [31:0] idx;
    logic [31:0] g;
    logic hit;
    int k;
    res = '{default: '0};
    res.status = STAT_OK;
    idx = h[31:0];
    hit = 1'b0;
    if (h[63:32] != 32'd0 && idx < 32'(water)) begin
      hit = (slot_gen[idx[7:0]] == h[63:32]);
    end
    case (op)
      OP_ADD: begin
        if (obj == 64'd0) begin
          res.status = STAT_NULL;
        end else if (free_top > 0) begin
          free_top = free_top - 1'b1;
          idx = {24'd0, free_idx[free_top]};
        end else if (water < SLOT_COUNT) begin
          idx = 32'(water);
          water = water + 1'b1;
        end else begin
          res.status = STAT_FULL;
        end
        if (res.status == STAT_OK) begin
          g = gen_next;
          gen_next = gen_next + 1'b1;
          if (g == 32'd0) begin
            g = gen_next;
            gen_next = gen_next + 1'b1;
          end
          slot_ref[idx[7:0]] = obj;
          slot_gen[idx[7:0]] = g;
          live = live + 1'b1;
          res.handle_out = {g, idx};
          live_handles = {live_handles, res.handle_out};
        end
      end
      OP_RESOLVE: begin
        if (h == 64'd0) begin
          res.status = STAT_NULL;
        end else if (hit) begin
          res.object_out = slot_ref[idx[7:0]];
        end else begin
          res.status = STAT_STALE;
        end
      end
      OP_REMOVE: begin
        if (h == 64'd0) begin
          res.status = STAT_NULL;
        end else if (hit) begin
          slot_ref[idx[7:0]] = '0;
          slot_gen[idx[7:0]] = '0;
          if (free_top < SLOT_COUNT) begin
            free_idx[free_top] = idx[7:0];
            free_top = free_top + 1'b1;
          end
          if (live > 0) begin
            live = live - 1'b1;
          end
          for (k = 0; k < live_handles.size(); k++) begin
            if (live_handles[k] == h) begin
              live_handles.delete(k);
              break;
            end
          end
          dead_handles = {dead_handles, h};
          if (dead_handles.size() > 64) begin
            void'(dead_handles.pop_front());
          end
        end else begin
          res.status = STAT_STALE;
        end
      end
      default: begin
        res.status = STAT_NULL;
      end
    endcase
    res.live_count = live;
    return res;
  endfunction

  task automatic note_error(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    table_result_t predicted;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted = apply_to_table(s_tuser, s_tdata[63:0], s_tdata[127:64]);
        pending_results = {pending_results, predicted};
        issued++;
      end
      if (m_tvalid && m_tready) begin
        retired++;
        if (pending_results.size() == 0) begin
          note_error("unexpected result transfer", 64'd0, m_tdata[63:0]);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[63:0] !== want.handle_out) begin
            note_error("handle_out", want.handle_out, m_tdata[63:0]);
          end
          if (m_tdata[127:64] !== want.object_out) begin
            note_error("object_out", want.object_out, m_tdata[127:64]);
          end
          if (m_tdata[136:128] !== want.live_count) begin
            note_error("live_count", 64'(want.live_count), 64'(m_tdata[136:128]));
          end
          if (m_tdata[143:137] !== 7'd0) begin
            note_error("tdata padding", 64'd0, 64'(m_tdata[143:137]));
          end
          if (m_tuser !== want.status) begin
            note_error("status", 64'(want.status), 64'(m_tuser));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[generational_handle_table] ERROR");
      $finish;
    end
  end

  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(logic [1:0] op, logic [63:0] obj, logic [63:0] h);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {h, obj};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (retired != issued) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && live_handles.size() > 0) begin
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
    end else if (r < 72 && dead_handles.size() > 0) begin
      return dead_handles[$urandom_range(0, dead_handles.size() - 1)];
    end else if (r < 80) begin
      return {32'($urandom), 32'($urandom_range(0, int'(water)))};
    end else if (r < 86) begin
      return {32'd0, 32'($urandom_range(0, SLOT_COUNT - 1))};
    end else if (r < 90) begin
      return 64'd0;
    end else if (r < 94 && live_handles.size() > 0) begin
      return {live_handles[$urandom_range(0, live_handles.size() - 1)][63:32],
              32'($urandom)};
    end
    return {32'($urandom), 32'($urandom)};
  endfunction

  task automatic random_request();
    int r;
    logic [63:0] obj;
    r = $urandom_range(0, 99);
    obj = {32'($urandom), 32'($urandom)};
    if (r < add_weight) begin
      send_request(OP_ADD, ($urandom_range(0, 29) == 0) ? 64'd0 : obj, pick_handle());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_request(OP_RESOLVE, obj, pick_handle());
      end else if (r < 92) begin
        send_request(OP_REMOVE, obj, pick_handle());
      end else begin
        send_request(OP_UNUSED, obj, pick_handle());
      end
    end
  endtask

  task automatic test_directed();
    logic [63:0] first;
    logic [63:0] gone;
    tx_gap_max = 17;
    rx_gap_max = 17;
    send_request(OP_ADD, 64'd0, 64'd0);
    send_request(OP_ADD, '1, '1);
    send_request(OP_ADD, 64'd1, 64'd0);
    send_request(OP_ADD, 64'h8000_0000_0000_0000, 64'd0);
    first = live_handles[0];
    gone = live_handles[1];
    send_request(OP_RESOLVE, 64'd0, first);
    send_request(OP_RESOLVE, 64'd0, live_handles[2]);
    send_request(OP_RESOLVE, 64'd0, 64'd0);
    send_request(OP_RESOLVE, 64'd0, {32'd0, 32'd1});
    send_request(OP_RESOLVE, 64'd0, {32'd1, 32'd200});
    send_request(OP_RESOLVE, '1, '1);
    send_request(OP_REMOVE, 64'd0, gone);
    send_request(OP_REMOVE, 64'd0, gone);
    send_request(OP_RESOLVE, 64'd0, gone);
    send_request(OP_ADD, 64'h0123_4567_89ab_cdef, 64'd0);
    send_request(OP_RESOLVE, 64'd0, live_handles[live_handles.size() - 1]);
    send_request(OP_REMOVE, '1, 64'd0);
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_UNUSED, 64'd0, 64'd0);
    send_request(OP_REMOVE, 64'd0, {first[63:32], 32'hFFFF_FFFF});
    send_request(OP_REMOVE, 64'd0, first);
    wait_idle();
  endtask

  task automatic test_fill_table();
    tx_gap_max = 0;
    rx_gap_max = 0;
    while (!(free_top == 0 && water == SLOT_COUNT)) begin
      send_request(OP_ADD, {32'($urandom), 32'($urandom)}, 64'd0);
    end
    repeat (3) send_request(OP_ADD, {32'($urandom), 32'($urandom)}, 64'd0);
    repeat (4) begin
      send_request(OP_RESOLVE, 64'd0,
                   live_handles[$urandom_range(0, live_handles.size() - 1)]);
    end
    wait_idle();
    tx_gap_max = 17;
    rx_gap_max = 17;
    while (live_handles.size() > 0) begin
      send_request(OP_REMOVE, {32'($urandom), 32'($urandom)},
                   live_handles[$urandom_range(0, live_handles.size() - 1)]);
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 3;
    add_weight = 50;
    hold_cycles = 300;
    repeat (40) random_request();
    wait_idle();
  endtask

  task automatic test_random();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      tx_gap_max = (phase % 3 == 0) ? 0 : 17;
      rx_gap_max = (phase % 2 == 0) ? 17 : 0;
      add_weight = (phase % 3 == 0) ? 55 : ((phase % 3 == 1) ? 40 : 20);
      repeat (100) random_request();
      if (phase % 2 == 1) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_ADD;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_table();
    test_backpressure();
    test_random();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_error("results never delivered", 64'(pending_results.size()), 64'd0);
    end
    if (errors == 0) begin
      $display("[generational_handle_table] OK");
    end else begin
      $display("[generational_handle_table] ERROR");
    end
    $finish;
  end

endmodule
